// ===== sv/acbs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
`default_nettype none
package acbs_pkg;
    localparam int MAX_STATES       = 256;
    localparam int ALPHABET         = 128;
    localparam int VALUES_PER_STATE = 8;
    localparam int MAX_OUT          = 8;

    localparam int ST_W  = $clog2(MAX_STATES);
    localparam int CH_W  = $clog2(ALPHABET);
    localparam int VI_W  = $clog2(VALUES_PER_STATE);
    localparam int VC_W  = $clog2(VALUES_PER_STATE + 1);
    localparam int GT_W  = ST_W + 1;
    localparam int GT_AW = ST_W + CH_W;
    localparam int VL_AW = ST_W + VI_W;
    localparam int VAL_W = 8;
    localparam int OUT_W = 8;

    localparam logic [2:0] REQ_KEY     = 3'd0;
    localparam logic [2:0] REQ_END     = 3'd1;
    localparam logic [2:0] REQ_BUILD   = 3'd2;
    localparam logic [2:0] REQ_SCAN    = 3'd3;
    localparam logic [2:0] REQ_RESTART = 3'd4;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_STATES = 2'd1;
    localparam logic [1:0] ERR_LIST   = 2'd2;
    localparam logic [1:0] ERR_PHASE  = 2'd3;

    localparam logic [6:0] CHAR_ONE = 7'h31;
    localparam logic [6:0] CHAR_TWO = 7'h32;
    localparam logic [6:0] CHAR_AT  = 7'h40;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 5'd1;
    localparam logic [OP_W-1:0] OP_LATCH      = 5'd2;
    localparam logic [OP_W-1:0] OP_KEY_RD     = 5'd3;
    localparam logic [OP_W-1:0] OP_KEY_UPD    = 5'd4;
    localparam logic [OP_W-1:0] OP_END_RD     = 5'd5;
    localparam logic [OP_W-1:0] OP_END_UPD    = 5'd6;
    localparam logic [OP_W-1:0] OP_RESTART    = 5'd7;
    localparam logic [OP_W-1:0] OP_PHASE_ERR  = 5'd8;
    localparam logic [OP_W-1:0] OP_SCAN_RD    = 5'd9;
    localparam logic [OP_W-1:0] OP_SCAN_STEP  = 5'd10;
    localparam logic [OP_W-1:0] OP_SCAN_OUT   = 5'd11;
    localparam logic [OP_W-1:0] OP_ROOT_RD    = 5'd12;
    localparam logic [OP_W-1:0] OP_ROOT_WR    = 5'd13;
    localparam logic [OP_W-1:0] OP_DQ_RD      = 5'd14;
    localparam logic [OP_W-1:0] OP_DQ_R       = 5'd15;
    localparam logic [OP_W-1:0] OP_DQ_F       = 5'd16;
    localparam logic [OP_W-1:0] OP_A_RD       = 5'd17;
    localparam logic [OP_W-1:0] OP_A_CHK      = 5'd18;
    localparam logic [OP_W-1:0] OP_A_INH      = 5'd19;
    localparam logic [OP_W-1:0] OP_F_RD       = 5'd20;
    localparam logic [OP_W-1:0] OP_F_CHK      = 5'd21;
    localparam logic [OP_W-1:0] OP_F_UP       = 5'd22;
    localparam logic [OP_W-1:0] OP_V_NF       = 5'd23;
    localparam logic [OP_W-1:0] OP_V_NS       = 5'd24;
    localparam logic [OP_W-1:0] OP_V_CHK      = 5'd25;
    localparam logic [OP_W-1:0] OP_V_ADD      = 5'd26;
    localparam logic [OP_W-1:0] OP_BUILD_DONE = 5'd27;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } acbs_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       built;
        logic [2:0] req;
        logic       gt_none;
        logic       a_last;
        logic       q_more;
        logic       v_more;
        logic       out_last;
    } acbs_stat_t;
endpackage
`default_nettype wire

// ===== sv/acbs_ctrl.sv =====
// Sequencer: decodes items and steps the datapath through each operation
`default_nettype none
module acbs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire acbs_pkg::acbs_stat_t stat,
    output acbs_pkg::acbs_cmd_t      cmd
);
    import acbs_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_KEY_RD  = 5'd3;
    localparam logic [4:0] S_KEY_UPD = 5'd4;
    localparam logic [4:0] S_END_RD  = 5'd5;
    localparam logic [4:0] S_END_UPD = 5'd6;
    localparam logic [4:0] S_RESTART = 5'd7;
    localparam logic [4:0] S_PHASE   = 5'd8;
    localparam logic [4:0] S_SCAN_RD = 5'd9;
    localparam logic [4:0] S_SCAN_ST = 5'd10;
    localparam logic [4:0] S_SCAN_OUT= 5'd11;
    localparam logic [4:0] S_ROOT_RD = 5'd12;
    localparam logic [4:0] S_ROOT_WR = 5'd13;
    localparam logic [4:0] S_DQ_CHK  = 5'd14;
    localparam logic [4:0] S_DQ_RD   = 5'd15;
    localparam logic [4:0] S_DQ_R    = 5'd16;
    localparam logic [4:0] S_DQ_F    = 5'd17;
    localparam logic [4:0] S_A_RD    = 5'd18;
    localparam logic [4:0] S_A_CHK   = 5'd19;
    localparam logic [4:0] S_A_INH   = 5'd20;
    localparam logic [4:0] S_F_RD    = 5'd21;
    localparam logic [4:0] S_F_CHK   = 5'd22;
    localparam logic [4:0] S_F_UP    = 5'd23;
    localparam logic [4:0] S_V_NF    = 5'd24;
    localparam logic [4:0] S_V_NS    = 5'd25;
    localparam logic [4:0] S_V_CHK   = 5'd26;
    localparam logic [4:0] S_V_ADD   = 5'd27;
    localparam logic [4:0] S_B_DONE  = 5'd28;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.req == REQ_KEY && !stat.built)
                    state_next = S_KEY_RD;
                else if (stat.req == REQ_END && !stat.built)
                    state_next = S_END_RD;
                else if (stat.req == REQ_BUILD && !stat.built)
                    state_next = S_ROOT_RD;
                else if (stat.req == REQ_SCAN && stat.built)
                    state_next = S_SCAN_RD;
                else if (stat.req == REQ_RESTART)
                    state_next = S_RESTART;
                else
                    state_next = S_PHASE;
            end
            S_KEY_RD:
            begin
                cmd.op = OP_KEY_RD;
                state_next = S_KEY_UPD;
            end
            S_KEY_UPD:
            begin
                cmd.op = OP_KEY_UPD;
                state_next = S_IDLE;
            end
            S_END_RD:
            begin
                cmd.op = OP_END_RD;
                state_next = S_END_UPD;
            end
            S_END_UPD:
            begin
                cmd.op = OP_END_UPD;
                state_next = S_IDLE;
            end
            S_RESTART:
            begin
                cmd.op = OP_RESTART;
                state_next = S_IDLE;
            end
            S_PHASE:
            begin
                cmd.op = OP_PHASE_ERR;
                state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                cmd.op = OP_SCAN_RD;
                state_next = S_SCAN_ST;
            end
            S_SCAN_ST:
            begin
                cmd.op = OP_SCAN_STEP;
                state_next = S_SCAN_OUT;
            end
            S_SCAN_OUT:
            begin
                cmd.op = OP_SCAN_OUT;
                if (stat.out_last)
                    state_next = S_IDLE;
            end
            S_ROOT_RD:
            begin
                cmd.op = OP_ROOT_RD;
                state_next = S_ROOT_WR;
            end
            S_ROOT_WR:
            begin
                cmd.op = OP_ROOT_WR;
                state_next = stat.a_last ? S_DQ_CHK : S_ROOT_RD;
            end
            S_DQ_CHK:
                state_next = stat.q_more ? S_DQ_RD : S_B_DONE;
            S_DQ_RD:
            begin
                cmd.op = OP_DQ_RD;
                state_next = S_DQ_R;
            end
            S_DQ_R:
            begin
                cmd.op = OP_DQ_R;
                state_next = S_DQ_F;
            end
            S_DQ_F:
            begin
                cmd.op = OP_DQ_F;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                cmd.op = OP_A_RD;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                cmd.op = OP_A_CHK;
                state_next = stat.gt_none ? S_A_INH : S_F_RD;
            end
            S_A_INH:
            begin
                cmd.op = OP_A_INH;
                state_next = stat.a_last ? S_DQ_CHK : S_A_RD;
            end
            S_F_RD:
            begin
                cmd.op = OP_F_RD;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                cmd.op = OP_F_CHK;
                state_next = stat.gt_none ? S_F_UP : S_V_NF;
            end
            S_F_UP:
            begin
                cmd.op = OP_F_UP;
                state_next = S_F_RD;
            end
            S_V_NF:
            begin
                cmd.op = OP_V_NF;
                state_next = S_V_NS;
            end
            S_V_NS:
            begin
                cmd.op = OP_V_NS;
                state_next = S_V_CHK;
            end
            S_V_CHK:
            begin
                cmd.op = OP_V_CHK;
                priority if (stat.v_more)
                    state_next = S_V_ADD;
                else if (stat.a_last)
                    state_next = S_DQ_CHK;
                else
                    state_next = S_A_RD;
            end
            S_V_ADD:
            begin
                cmd.op = OP_V_ADD;
                state_next = S_V_CHK;
            end
            S_B_DONE:
            begin
                cmd.op = OP_BUILD_DONE;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/acbs_dp.sv =====
// Datapath: trie, delta, failure, value and queue memories plus working registers
`default_nettype none
module acbs_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire acbs_pkg::acbs_cmd_t  cmd,
    output acbs_pkg::acbs_stat_t      stat,
    input  wire logic [2:0]           req_type,
    input  wire logic [6:0]           char_code,
    output logic                      done,
    output logic [7:0]                state_now,
    output logic [7:0]                path_value,
    output logic                      has_match,
    output logic                      last,
    output logic [1:0]                error_code
);
    import acbs_pkg::*;

    localparam logic [GT_W-1:0] GT_NONE = GT_W'(1) << ST_W;
    localparam logic [ST_W:0]   ST_MAX  = (ST_W+1)'(MAX_STATES);

    logic [GT_W-1:0]  gt_mem [2**GT_AW];
    logic [ST_W-1:0]  dl_mem [2**GT_AW];
    logic [ST_W-1:0]  fl_mem [2**ST_W];
    logic [VAL_W-1:0] vl_mem [2**VL_AW];
    logic [VC_W-1:0]  vc_mem [2**ST_W];
    logic [ST_W-1:0]  q_mem  [2**ST_W];

    logic             gt_we, gt_re, dl_we, dl_re, fl_we, fl_re;
    logic             vl_we, vl_re, vc_we, vc_re, q_we, q_re;
    logic [GT_AW-1:0] gt_wa, gt_ra, dl_wa, dl_ra;
    logic [GT_W-1:0]  gt_wd, gt_rd;
    logic [ST_W-1:0]  dl_wd, dl_rd, fl_wa, fl_ra, fl_wd, fl_rd;
    logic [VL_AW-1:0] vl_wa, vl_ra;
    logic [VAL_W-1:0] vl_wd, vl_rd;
    logic [ST_W-1:0]  vc_wa, vc_ra, q_wa, q_ra, q_wd, q_rd;
    logic [VC_W-1:0]  vc_wd, vc_rd;

    logic [2:0]       req_reg;
    logic [6:0]       chr_reg;
    logic [ST_W:0]    su_reg, su_next, head_reg, head_next, tail_reg, tail_next;
    logic [ST_W-1:0]  ins_reg, ins_next, scan_reg, scan_next;
    logic [ST_W-1:0]  r_reg, r_next, fr_reg, fr_next, f_reg, f_next;
    logic [ST_W-1:0]  s_reg, s_next, f2_reg, f2_next;
    logic [VAL_W-1:0] pc_reg, pc_next;
    logic             frozen_reg, frozen_next, built_reg, built_next, ok_reg, ok_next;
    logic [GT_AW:0]   clr_reg, clr_next;
    logic [CH_W-1:0]  a_reg, a_next;
    logic [VC_W-1:0]  i_reg, i_next, nf_reg, nf_next, ns_reg, ns_next, k_reg, k_next;

    logic             emit;
    logic [ST_W-1:0]  e_state;
    logic [VAL_W-1:0] e_val;
    logic             e_hit, e_last;
    logic [1:0]       e_err;

    logic [CH_W-1:0]  c;
    logic             gt_none;
    logic [ST_W-1:0]  g;
    logic [VC_W-1:0]  n_eff, k_inc;

    assign c       = chr_reg[CH_W-1:0];
    assign gt_none = gt_rd[ST_W];
    assign g       = gt_none ? '0 : gt_rd[ST_W-1:0];
    assign n_eff   = (vc_rd > VC_W'(MAX_OUT)) ? VC_W'(MAX_OUT) : vc_rd;
    assign k_inc   = k_reg + VC_W'(1);

    assign stat.clr_done = clr_reg[GT_AW];
    assign stat.built    = built_reg;
    assign stat.req      = req_reg;
    assign stat.gt_none  = gt_none;
    assign stat.a_last   = (a_reg == CH_W'(ALPHABET - 1));
    assign stat.q_more   = (head_reg < tail_reg);
    assign stat.v_more   = (i_reg < nf_reg);
    assign stat.out_last = (n_eff == '0) || (k_inc == n_eff);

    always_ff @(posedge clk)
    begin
        if (gt_we)
            gt_mem[gt_wa] <= gt_wd;
        if (gt_re)
            gt_rd <= gt_mem[gt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_wa] <= dl_wd;
        if (dl_re)
            dl_rd <= dl_mem[dl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
            fl_mem[fl_wa] <= fl_wd;
        if (fl_re)
            fl_rd <= fl_mem[fl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vl_we)
            vl_mem[vl_wa] <= vl_wd;
        if (vl_re)
            vl_rd <= vl_mem[vl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vc_we)
            vc_mem[vc_wa] <= vc_wd;
        if (vc_re)
            vc_rd <= vc_mem[vc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        if (q_re)
            q_rd <= q_mem[q_ra];
    end

    always_comb
    begin
        gt_we = 1'b0; gt_re = 1'b0; gt_wa = '0; gt_ra = '0; gt_wd = '0;
        dl_we = 1'b0; dl_re = 1'b0; dl_wa = '0; dl_ra = '0; dl_wd = '0;
        fl_we = 1'b0; fl_re = 1'b0; fl_wa = '0; fl_ra = '0; fl_wd = '0;
        vl_we = 1'b0; vl_re = 1'b0; vl_wa = '0; vl_ra = '0; vl_wd = '0;
        vc_we = 1'b0; vc_re = 1'b0; vc_wa = '0; vc_ra = '0; vc_wd = '0;
        q_we  = 1'b0; q_re  = 1'b0; q_wa  = '0; q_ra  = '0; q_wd  = '0;
        su_next = su_reg; head_next = head_reg; tail_next = tail_reg;
        ins_next = ins_reg; scan_next = scan_reg; r_next = r_reg; fr_next = fr_reg;
        f_next = f_reg; s_next = s_reg; f2_next = f2_reg; pc_next = pc_reg;
        frozen_next = frozen_reg; built_next = built_reg; ok_next = ok_reg;
        clr_next = clr_reg; a_next = a_reg; i_next = i_reg; nf_next = nf_reg;
        ns_next = ns_reg; k_next = k_reg;
        emit = 1'b0; e_state = '0; e_val = '0; e_hit = 1'b0; e_last = 1'b1;
        e_err = ERR_OK;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                if (!clr_reg[GT_AW])
                begin
                    gt_we = 1'b1;
                    gt_wa = clr_reg[GT_AW-1:0];
                    gt_wd = GT_NONE;
                    vc_we = 1'b1;
                    vc_wa = clr_reg[ST_W-1:0];
                    vc_wd = '0;
                    clr_next = clr_reg + (GT_AW+1)'(1);
                end
            end
            OP_LATCH:
            begin
                head_next = '0;
                tail_next = '0;
                ok_next   = 1'b1;
                a_next    = '0;
            end
            OP_KEY_RD:
            begin
                gt_re = 1'b1;
                gt_ra = {ins_reg, c};
            end
            OP_KEY_UPD:
            begin
                priority if (!gt_none)
                    ins_next = gt_rd[ST_W-1:0];
                else if (su_reg < ST_MAX)
                begin
                    gt_we    = 1'b1;
                    gt_wa    = {ins_reg, c};
                    gt_wd    = {1'b0, su_reg[ST_W-1:0]};
                    ins_next = su_reg[ST_W-1:0];
                    su_next  = su_reg + (ST_W+1)'(1);
                end
                else
                    e_err = ERR_STATES;
                if (!frozen_reg && chr_reg != CHAR_ONE && chr_reg != CHAR_TWO)
                begin
                    if (pc_reg != '1)
                        pc_next = pc_reg + VAL_W'(1);
                    if (chr_reg != CHAR_AT)
                        frozen_next = 1'b1;
                end
                emit    = 1'b1;
                e_state = ins_next;
            end
            OP_END_RD:
            begin
                vc_re = 1'b1;
                vc_ra = ins_reg;
            end
            OP_END_UPD:
            begin
                if (vc_rd < VC_W'(VALUES_PER_STATE))
                begin
                    vl_we = 1'b1;
                    vl_wa = {ins_reg, vc_rd[VI_W-1:0]};
                    vl_wd = pc_reg;
                    vc_we = 1'b1;
                    vc_wa = ins_reg;
                    vc_wd = vc_rd + VC_W'(1);
                    e_hit = 1'b1;
                end
                else
                    e_err = ERR_LIST;
                emit        = 1'b1;
                e_state     = ins_reg;
                e_val       = pc_reg;
                ins_next    = '0;
                pc_next     = '0;
                frozen_next = 1'b0;
            end
            OP_RESTART:
            begin
                scan_next = '0;
                emit      = 1'b1;
                e_state   = built_reg ? '0 : ins_reg;
            end
            OP_PHASE_ERR:
            begin
                emit    = 1'b1;
                e_state = built_reg ? scan_reg : ins_reg;
                e_err   = ERR_PHASE;
            end
            OP_SCAN_RD:
            begin
                dl_re = 1'b1;
                dl_ra = {scan_reg, c};
            end
            OP_SCAN_STEP:
            begin
                scan_next = dl_rd;
                vc_re     = 1'b1;
                vc_ra     = dl_rd;
                vl_re     = 1'b1;
                vl_ra     = {dl_rd, VI_W'(0)};
                k_next    = '0;
            end
            OP_SCAN_OUT:
            begin
                emit    = 1'b1;
                e_state = scan_reg;
                if (n_eff != '0)
                begin
                    e_val  = vl_rd;
                    e_hit  = 1'b1;
                    e_last = (k_inc == n_eff);
                    k_next = k_inc;
                    vl_re  = 1'b1;
                    vl_ra  = {scan_reg, k_inc[VI_W-1:0]};
                end
            end
            OP_ROOT_RD:
            begin
                gt_re = 1'b1;
                gt_ra = {ST_W'(0), a_reg};
            end
            OP_ROOT_WR:
            begin
                if (gt_none)
                begin
                    gt_we = 1'b1;
                    gt_wa = {ST_W'(0), a_reg};
                    gt_wd = '0;
                end
                dl_we = 1'b1;
                dl_wa = {ST_W'(0), a_reg};
                dl_wd = g;
                if (g != '0 && tail_reg < ST_MAX)
                begin
                    fl_we     = 1'b1;
                    fl_wa     = g;
                    fl_wd     = '0;
                    q_we      = 1'b1;
                    q_wa      = tail_reg[ST_W-1:0];
                    q_wd      = g;
                    tail_next = tail_reg + (ST_W+1)'(1);
                end
                a_next = a_reg + CH_W'(1);
            end
            OP_DQ_RD:
            begin
                q_re      = 1'b1;
                q_ra      = head_reg[ST_W-1:0];
                head_next = head_reg + (ST_W+1)'(1);
            end
            OP_DQ_R:
            begin
                r_next = q_rd;
                fl_re  = 1'b1;
                fl_ra  = q_rd;
            end
            OP_DQ_F:
            begin
                fr_next = fl_rd;
                a_next  = '0;
            end
            OP_A_RD:
            begin
                gt_re = 1'b1;
                gt_ra = {r_reg, a_reg};
            end
            OP_A_CHK:
            begin
                if (gt_none)
                begin
                    dl_re = 1'b1;
                    dl_ra = {fr_reg, a_reg};
                end
                else
                begin
                    s_next = gt_rd[ST_W-1:0];
                    f_next = fr_reg;
                    if (tail_reg < ST_MAX)
                    begin
                        q_we      = 1'b1;
                        q_wa      = tail_reg[ST_W-1:0];
                        q_wd      = gt_rd[ST_W-1:0];
                        tail_next = tail_reg + (ST_W+1)'(1);
                    end
                end
            end
            OP_A_INH:
            begin
                dl_we  = 1'b1;
                dl_wa  = {r_reg, a_reg};
                dl_wd  = dl_rd;
                a_next = a_reg + CH_W'(1);
            end
            OP_F_RD:
            begin
                gt_re = 1'b1;
                gt_ra = {f_reg, a_reg};
            end
            OP_F_CHK:
            begin
                if (gt_none)
                begin
                    fl_re = 1'b1;
                    fl_ra = f_reg;
                end
                else
                begin
                    f2_next = gt_rd[ST_W-1:0];
                    fl_we   = 1'b1;
                    fl_wa   = s_reg;
                    fl_wd   = gt_rd[ST_W-1:0];
                    dl_we   = 1'b1;
                    dl_wa   = {r_reg, a_reg};
                    dl_wd   = s_reg;
                    vc_re   = 1'b1;
                    vc_ra   = gt_rd[ST_W-1:0];
                end
            end
            OP_F_UP:
                f_next = fl_rd;
            OP_V_NF:
            begin
                nf_next = vc_rd;
                vc_re   = 1'b1;
                vc_ra   = s_reg;
            end
            OP_V_NS:
            begin
                ns_next = vc_rd;
                i_next  = '0;
            end
            OP_V_CHK:
            begin
                if (i_reg < nf_reg)
                begin
                    vl_re = 1'b1;
                    vl_ra = {f2_reg, i_reg[VI_W-1:0]};
                end
                else
                begin
                    vc_we  = 1'b1;
                    vc_wa  = s_reg;
                    vc_wd  = ns_reg;
                    a_next = a_reg + CH_W'(1);
                end
            end
            OP_V_ADD:
            begin
                if (ns_reg < VC_W'(VALUES_PER_STATE))
                begin
                    vl_we   = 1'b1;
                    vl_wa   = {s_reg, ns_reg[VI_W-1:0]};
                    vl_wd   = vl_rd;
                    ns_next = ns_reg + VC_W'(1);
                end
                else
                    ok_next = 1'b0;
                i_next = i_reg + VC_W'(1);
            end
            OP_BUILD_DONE:
            begin
                built_next = 1'b1;
                scan_next  = '0;
                emit       = 1'b1;
                e_err      = ok_reg ? ERR_OK : ERR_LIST;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_reg     <= (ST_W+1)'(1);
            ins_reg    <= '0;
            pc_reg     <= '0;
            frozen_reg <= 1'b0;
            scan_reg   <= '0;
            built_reg  <= 1'b0;
            clr_reg    <= '0;
            done       <= 1'b0;
        end
        else
        begin
            su_reg     <= su_next;
            ins_reg    <= ins_next;
            pc_reg     <= pc_next;
            frozen_reg <= frozen_next;
            scan_reg   <= scan_next;
            built_reg  <= built_next;
            clr_reg    <= clr_next;
            done       <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            req_reg <= req_type;
            chr_reg <= char_code;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
        r_reg    <= r_next;
        fr_reg   <= fr_next;
        f_reg    <= f_next;
        s_reg    <= s_next;
        f2_reg   <= f2_next;
        ok_reg   <= ok_next;
        a_reg    <= a_next;
        i_reg    <= i_next;
        nf_reg   <= nf_next;
        ns_reg   <= ns_next;
        k_reg    <= k_next;
        if (emit)
        begin
            state_now  <= OUT_W'(e_state);
            path_value <= e_val;
            has_match  <= e_hit;
            last       <= e_last;
            error_code <= e_err;
        end
    end
endmodule
`default_nettype wire

// ===== sv/aho_corasick_build_and_scan.sv =====
// Top level: keyword trie builder and multi-pattern scanner
//
//   channel   signals                                          handshake
//   item in   req_type, char_code                              start & !busy
//   result    state_now, path_value, has_match, last,          done (one cycle)
//             error_code
//
// After reset a clearing pass empties the trie; busy stays high.
// A keyword char reads and then updates its trie edge; an end of keyword reads and
// then updates the value count. A scan char reads the delta table, and the delta read
// feeds the value-count read. Build fills the root row first, then for each queued
// state walks the whole alphabet, with extra steps per child edge, per failure-chain
// step and per value copied.
// Results appear one per cycle and cannot be stalled by the receiver.
`default_nettype none
module aho_corasick_build_and_scan (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] req_type,
    input  wire logic [6:0] char_code,
    output logic            done,
    output logic [7:0]      state_now,
    output logic [7:0]      path_value,
    output logic            has_match,
    output logic            last,
    output logic [1:0]      error_code
);
    import acbs_pkg::*;

    acbs_cmd_t  cmd;
    acbs_stat_t stat;

    acbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    acbs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .char_code  (char_code),
        .done       (done),
        .state_now  (state_now),
        .path_value (path_value),
        .has_match  (has_match),
        .last       (last),
        .error_code (error_code)
    );

`ifndef NO_ASSERTIONS
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result right after accept");
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> done)
        else $error("gap inside a result burst");
    a_burst_is_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (has_match && error_code == ERR_OK))
        else $error("non-final result without a match");
    a_phase_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_code == ERR_PHASE) |-> (last && !has_match))
        else $error("bad phase result malformed");
`endif
endmodule
`default_nettype wire

// ===== tb/ac_result_checker.sv =====
// Keyword automaton predictor and result comparator for the build-and-scan block
`default_nettype none
module ac_result_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [2:0] req_type,
    input  wire logic [6:0] char_code,
    input  wire logic       done,
    input  wire logic [7:0] state_now,
    input  wire logic [7:0] path_value,
    input  wire logic       has_match,
    input  wire logic       last,
    input  wire logic [1:0] error_code,
    output int              fail_count,
    output int              pending,
    output int              results_seen,
    output int              match_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import acbs_pkg::*;

    localparam int EDGE_NONE = -1;

    typedef struct packed {
        logic [7:0] state;
        logic [7:0] value;
        logic       hit;
        logic       fin;
        logic [1:0] err;
    } ac_result_t;

    ac_result_t expected_results[$];

    // shadow automaton
    int trie_edge   [MAX_STATES*ALPHABET];
    int step_table  [MAX_STATES*ALPHABET];
    int fail_state  [MAX_STATES];
    int stored_val  [MAX_STATES*VALUES_PER_STATE];
    int stored_cnt  [MAX_STATES];
    int visit_queue [MAX_STATES];
    int node_total;
    int key_state;
    int key_count;
    bit key_frozen;
    int scan_pos;
    bit built;

    initial
    begin
        for (int i = 0; i < MAX_STATES*ALPHABET; i++)
        begin
            trie_edge[i]  = EDGE_NONE;
            step_table[i] = 0;
        end
        for (int i = 0; i < MAX_STATES; i++)
        begin
            fail_state[i] = 0;
            stored_cnt[i] = 0;
        end
        node_total = 1;
        key_state  = 0;
        key_count  = 0;
        key_frozen = 0;
        scan_pos   = 0;
        built      = 0;
        fail_count = 0;
        results_seen = 0;
        match_count  = 0;
    end

    assign pending = expected_results.size();

    function automatic bit store_value(int s, int v);
        if (stored_cnt[s] >= VALUES_PER_STATE)
            return 0;
        stored_val[s*VALUES_PER_STATE + stored_cnt[s]] = v;
        stored_cnt[s]++;
        return 1;
    endfunction

    function automatic bit build_automaton();
        int head, tail, r, s, f;
        bit ok;
        head = 0;
        tail = 0;
        ok   = 1;
        for (int a = 0; a < ALPHABET; a++)
        begin
            if (trie_edge[a] == EDGE_NONE)
                trie_edge[a] = 0;
            step_table[a] = trie_edge[a];
            if (trie_edge[a] != 0 && tail < MAX_STATES)
            begin
                fail_state[trie_edge[a]] = 0;
                visit_queue[tail++] = trie_edge[a];
            end
        end
        while (head < tail)
        begin
            r = visit_queue[head++];
            for (int a = 0; a < ALPHABET; a++)
            begin
                s = trie_edge[r*ALPHABET + a];
                if (s != EDGE_NONE)
                begin
                    f = fail_state[r];
                    if (tail < MAX_STATES)
                        visit_queue[tail++] = s;
                    while (trie_edge[f*ALPHABET + a] == EDGE_NONE)
                        f = fail_state[f];
                    f = trie_edge[f*ALPHABET + a];
                    fail_state[s] = f;
                    for (int i = 0; i < stored_cnt[f]; i++)
                        if (!store_value(s, stored_val[f*VALUES_PER_STATE + i]))
                            ok = 0;
                    step_table[r*ALPHABET + a] = s;
                end
                else
                    step_table[r*ALPHABET + a] = step_table[fail_state[r]*ALPHABET + a];
            end
        end
        return ok;
    endfunction

    function automatic void push_result(int st, int val, bit hit, bit fin, logic [1:0] err);
        ac_result_t x;
        x.state = st[7:0];
        x.value = val[7:0];
        x.hit   = hit;
        x.fin   = fin;
        x.err   = err;
        expected_results.push_back(x);
    endfunction

    function automatic void predict_item_results(logic [2:0] req, logic [6:0] ch);
        int c, nxt, n;
        logic [1:0] err;
        bit ok;
        c = int'(ch) % ALPHABET;
        if (req == REQ_KEY && !built)
        begin
            err = ERR_OK;
            nxt = trie_edge[key_state*ALPHABET + c];
            if (nxt != EDGE_NONE)
                key_state = nxt;
            else if (node_total < MAX_STATES)
            begin
                trie_edge[key_state*ALPHABET + c] = node_total;
                key_state = node_total;
                node_total++;
            end
            else
                err = ERR_STATES;
            if (!key_frozen && ch != CHAR_ONE && ch != CHAR_TWO)
            begin
                if (key_count < 255)
                    key_count++;
                if (ch != CHAR_AT)
                    key_frozen = 1;
            end
            push_result(key_state, 0, 0, 1, err);
        end
        else if (req == REQ_END && !built)
        begin
            ok = store_value(key_state, key_count);
            push_result(key_state, key_count, ok, 1, ok ? ERR_OK : ERR_LIST);
            key_state  = 0;
            key_count  = 0;
            key_frozen = 0;
        end
        else if (req == REQ_BUILD && !built)
        begin
            ok = build_automaton();
            built    = 1;
            scan_pos = 0;
            push_result(0, 0, 0, 1, ok ? ERR_OK : ERR_LIST);
        end
        else if (req == REQ_SCAN && built)
        begin
            scan_pos = step_table[scan_pos*ALPHABET + c];
            n = stored_cnt[scan_pos];
            if (n > MAX_OUT)
                n = MAX_OUT;
            if (n == 0)
                push_result(scan_pos, 0, 0, 1, ERR_OK);
            for (int k = 0; k < n; k++)
                push_result(scan_pos, stored_val[scan_pos*VALUES_PER_STATE + k], 1,
                            k + 1 == n, ERR_OK);
        end
        else if (req == REQ_RESTART)
        begin
            scan_pos = 0;
            push_result(built ? 0 : key_state, 0, 0, 1, ERR_OK);
        end
        else
            push_result(built ? scan_pos : key_state, 0, 0, 1, ERR_PHASE);
    endfunction

    always @(posedge clk)
    begin
        ac_result_t exp_r;
        if (rst_n && done)
        begin
            results_seen++;
            if (has_match)
                match_count++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: state_now %0d path_value %0d", state_now,
                       path_value);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (state_now !== exp_r.state)
                begin
                    $error("state_now: expected %0d, got %0d", exp_r.state, state_now);
                    fail_count++;
                end
                if (path_value !== exp_r.value)
                begin
                    $error("path_value: expected %0d, got %0d", exp_r.value, path_value);
                    fail_count++;
                end
                if (has_match !== exp_r.hit)
                begin
                    $error("has_match: expected %0d, got %0d", exp_r.hit, has_match);
                    fail_count++;
                end
                if (last !== exp_r.fin)
                begin
                    $error("last: expected %0d, got %0d", exp_r.fin, last);
                    fail_count++;
                end
                if (error_code !== exp_r.err)
                begin
                    $error("error_code: expected %0d, got %0d", exp_r.err, error_code);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy)
            predict_item_results(req_type, char_code);
    end
endmodule
`default_nettype wire

// ===== tb/tb_aho_corasick_build_and_scan.sv =====
// Stimulus and verdict for the keyword automaton build-and-scan block
`default_nettype none
module tb_aho_corasick_build_and_scan;
    timeunit 1ns;
    timeprecision 1ps;
    import acbs_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       start = 0;
    logic [2:0] req_type = REQ_KEY;
    logic [6:0] char_code = 0;
    logic       busy, done, has_match, last;
    logic [7:0] state_now, path_value;
    logic [1:0] error_code;
    int         fail_count, pending, results_seen, match_count;
    int         items_sent = 0;
    int         idle_pct = 0;
    int         cycles = 0;

    aho_corasick_build_and_scan dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .char_code(char_code), .done(done),
        .state_now(state_now), .path_value(path_value), .has_match(has_match),
        .last(last), .error_code(error_code)
    );

    ac_result_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .char_code(char_code), .done(done),
        .state_now(state_now), .path_value(path_value), .has_match(has_match),
        .last(last), .error_code(error_code), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen), .match_count(match_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_aho_corasick_build_and_scan: FAIL");
            $finish;
        end
    end

    // mostly a tiny alphabet so scans hit keywords; sometimes any 7-bit code
    function automatic logic [6:0] pick_char();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return CHAR_ONE;
            1: return CHAR_TWO;
            2: return CHAR_AT;
            8, 9: return 7'($urandom_range(127));
            default: return 7'(8'h61 + r - 3);
        endcase
    endfunction

    task automatic send_item(input logic [2:0] r, input logic [6:0] c);
        case ((items_sent / 30) % 4)
            1: idle_pct = 76;
            3: idle_pct = 20;
            default: idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start     <= 1;
        req_type  <= r;
        char_code <= c;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    initial
    begin
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // directed: char extremes, counting rules, phase errors before build
        send_item(REQ_KEY, 7'd0);
        send_item(REQ_KEY, 7'd127);
        send_item(REQ_END, 7'd0);
        send_item(REQ_KEY, CHAR_ONE);
        send_item(REQ_KEY, CHAR_TWO);
        send_item(REQ_KEY, CHAR_AT);
        send_item(REQ_KEY, CHAR_AT);
        send_item(REQ_KEY, 7'h61);
        send_item(REQ_KEY, 7'h62);
        send_item(REQ_END, 7'h7f);
        send_item(REQ_SCAN, 7'h61);
        send_item(REQ_RESTART, 7'd0);
        send_item(3'd5, 7'd0);
        send_item(3'd6, 7'd0);
        send_item(3'd7, 7'h55);
        // empty keywords pile values on the root until its list overflows
        repeat (9) send_item(REQ_END, 7'h2a);

        // random keywords over a small alphabet, with some noise
        repeat (18)
        begin
            len = $urandom_range(0, 4);
            repeat (len) send_item(REQ_KEY, pick_char());
            if ($urandom_range(14) == 0)
                send_item($urandom_range(1) ? REQ_RESTART : 3'($urandom_range(5, 7)),
                          7'($urandom_range(127)));
            send_item(REQ_END, 7'($urandom_range(127)));
        end
        send_item(REQ_BUILD, 7'd0);
        send_item(REQ_BUILD, 7'd0);

        repeat (75)
        begin
            len = $urandom_range(99);
            if (len < 70)
                send_item(REQ_SCAN, pick_char());
            else if (len < 80)
                send_item(REQ_SCAN, 7'($urandom_range(127)));
            else if (len < 88)
                send_item(REQ_RESTART, 7'($urandom_range(127)));
            else
                send_item(3'($urandom_range(7)), 7'($urandom_range(127)));
        end
        start <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d items: keyword load with list overflow,", items_sent);
        $display("build, and scans giving %0d results (%0d matches)", results_seen,
                 match_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_aho_corasick_build_and_scan: PASS");
        else
            $display("tb_aho_corasick_build_and_scan: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/acbs_pkg.sv
sv/acbs_ctrl.sv
sv/acbs_dp.sv
sv/aho_corasick_build_and_scan.sv
tb/ac_result_checker.sv
tb/tb_aho_corasick_build_and_scan.sv
